// File: rtl/core/bfb_pkg.sv
// Shared types, opcodes and CRC step for the bridge frame builder and checker.
`timescale 1ns / 1ps
`default_nettype none

package bfb_pkg;

  localparam logic [2:0] OP_SINGLE_WR = 3'd0;
  localparam logic [2:0] OP_STACK_WR  = 3'd1;
  localparam logic [2:0] OP_BCAST_WR  = 3'd2;
  localparam logic [2:0] OP_SINGLE_RD = 3'd3;
  localparam logic [2:0] OP_STACK_RD  = 3'd4;
  localparam logic [2:0] OP_CHK_SINGLE = 3'd5;
  localparam logic [2:0] OP_CHK_STACK  = 3'd6;
  localparam logic [2:0] OP_RESERVED   = 3'd7;

  localparam logic [7:0] CMD_SINGLE_WR = 8'h90;
  localparam logic [7:0] CMD_STACK_WR  = 8'hB0;
  localparam logic [7:0] CMD_BCAST_WR  = 8'hD0;
  localparam logic [7:0] CMD_SINGLE_RD = 8'h80;
  localparam logic [7:0] CMD_STACK_RD  = 8'hA0;
  localparam logic [7:0] STACK_RD_DATA = 8'h01;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned NumBytes = 5;
  localparam int unsigned NumStages = NumBytes + 1;

  typedef struct packed {
    logic                        is_chk;
    logic [2:0]                  len;
    logic [NumBytes-1:0][7:0]    bytes;
    logic [15:0]                 crc;
    logic [15:0]                 got_crc;
    logic                        ok_pre;
    logic [7:0]                  rdata;
  } item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in, input logic [7:0] b);
    logic [15:0] acc;
    acc = acc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bfb_serializer.sv
// Output stage: sends frame bytes one per cycle, or one check result.
`timescale 1ns / 1ps
`default_nettype none

module bfb_serializer
  import bfb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire item_t       item_i,
  output logic             free_o,
  output logic             valid_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_o,
  output logic             is_chk_o,
  output logic             ok_o,
  output logic [7:0]       rdata_o
);

  logic             vld_q;
  logic [2:0]       rem_q;
  logic [6:0][7:0]  sh_q;
  logic [6:0][7:0]  sh_d;
  logic             chk_q;
  logic             ok_q;
  logic [7:0]       rd_q;
  logic [2:0]       len_d;
  logic [2:0]       crc_pos;

  always_comb begin
    crc_pos = item_i.len;
    for (int i = 0; i < 7; i++) begin
      if (item_i.is_chk) begin
        sh_d[i] = 8'h00;
      end else if (3'(i) < item_i.len) begin
        sh_d[i] = item_i.bytes[i % NumBytes];
      end else if (3'(i) == crc_pos) begin
        sh_d[i] = item_i.crc[7:0];
      end else if (3'(i) == crc_pos + 3'd1) begin
        sh_d[i] = item_i.crc[15:8];
      end else begin
        sh_d[i] = 8'h00;
      end
    end
    len_d = item_i.is_chk ? 3'd1 : item_i.len + 3'd2;
  end

  assign free_o = !vld_q || (rem_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= 3'd0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      rem_q <= len_d;
    end else if (vld_q) begin
      rem_q <= rem_q - 3'd1;
      if (rem_q == 3'd1) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sh_q  <= sh_d;
      chk_q <= item_i.is_chk;
      ok_q  <= item_i.is_chk && item_i.ok_pre && (item_i.crc == item_i.got_crc);
      rd_q  <= item_i.is_chk ? item_i.rdata : 8'h00;
    end else if (vld_q) begin
      sh_q <= {8'h00, sh_q[6:1]};
    end
  end

  assign valid_o      = vld_q;
  assign frame_byte_o = sh_q[0];
  assign last_o       = (rem_q == 3'd1);
  assign is_chk_o     = chk_q;
  assign ok_o         = ok_q;
  assign rdata_o      = rd_q;

endmodule

`default_nettype wire

// File: rtl/core/bridge_frame_builder_checker.sv
// Top level: bridge command frame builder and read reply checker.
//
//  channel   | direction | transaction marker      | payload
//  ----------+-----------+-------------------------+------------------------------------
//  command   | in        | start && !busy          | opcode, addresses, value, reply
//  result    | out       | result_valid_o          | frame byte, last, check, ok, data
//
// A request enters an assembly stage, then five CRC stages, one frame byte each.
// Frame requests leave 6 or 7 bytes, one per cycle; a check leaves one result.
// Sustained rate is set by the output serializer: it loads a new item when idle or as the last
// result of the previous one goes out, and its output is registered after the CRC stages.
// Reset clears all valid bits; busy holds while the pipeline is backed up behind
// the serializer. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module bridge_frame_builder_checker
  import bfb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [5:0]  device_address_i,
  input  wire logic [15:0] register_address_i,
  input  wire logic [7:0]  write_value_i,
  input  wire logic [55:0] reply_bytes_i,
  output logic             result_valid_o,
  output logic [7:0]       frame_byte_o,
  output logic             last_of_run_o,
  output logic             is_check_result_o,
  output logic             reply_ok_o,
  output logic [7:0]       read_data_o
);

  logic [NumStages-1:0] vld_q, vld_d, adv;
  item_t                pipe_q [NumStages];
  item_t                pipe_d [NumStages];
  item_t                asm_item;
  logic                 accept, take;
  logic                 ser_free;
  logic                 shift;
  logic [7:0]           got_dev;
  logic [15:0]          got_reg;

  assign accept = start && !busy;
  assign take   = accept && (opcode_i != OP_RESERVED);

  always_comb begin
    adv[NumStages-1] = vld_q[NumStages-1] && ser_free;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = vld_q[k] && (!vld_q[k+1] || adv[k+1]);
    end
  end

  assign busy = vld_q[0] && !adv[0];

  always_comb begin
    shift   = (reply_bytes_i[7:0] == 8'h00);
    got_dev = shift ? reply_bytes_i[15:8] : reply_bytes_i[7:0];
    got_reg = shift ? {reply_bytes_i[23:16], reply_bytes_i[31:24]}
                    : {reply_bytes_i[15:8], reply_bytes_i[23:16]};
    asm_item         = '0;
    asm_item.crc     = CRC_INIT;
    asm_item.got_crc = shift ? reply_bytes_i[55:40] : reply_bytes_i[47:32];
    asm_item.rdata   = shift ? reply_bytes_i[39:32] : reply_bytes_i[31:24];
    unique case (opcode_i)
      OP_SINGLE_WR, OP_SINGLE_RD: begin
        asm_item.len   = 3'd5;
        asm_item.bytes = {(opcode_i == OP_SINGLE_WR) ? write_value_i : 8'h00,
                          register_address_i[7:0], register_address_i[15:8],
                          {2'b00, device_address_i},
                          (opcode_i == OP_SINGLE_WR) ? CMD_SINGLE_WR : CMD_SINGLE_RD};
      end
      OP_STACK_WR, OP_BCAST_WR, OP_STACK_RD: begin
        asm_item.len   = 3'd4;
        asm_item.bytes = {8'h00,
                          (opcode_i == OP_STACK_RD) ? STACK_RD_DATA : write_value_i,
                          register_address_i[7:0], register_address_i[15:8],
                          (opcode_i == OP_STACK_WR) ? CMD_STACK_WR :
                          (opcode_i == OP_BCAST_WR) ? CMD_BCAST_WR : CMD_STACK_RD};
      end
      default: begin
        asm_item.is_chk = 1'b1;
        asm_item.len    = shift ? 3'd5 : 3'd4;
        asm_item.bytes  = reply_bytes_i[39:0];
        asm_item.ok_pre = (got_reg == register_address_i) &&
                          ((opcode_i == OP_CHK_STACK) || (got_dev == {2'b00, device_address_i}));
      end
    endcase
  end

  always_comb begin
    pipe_d[0] = asm_item;
    vld_d[0]  = take || (vld_q[0] && !adv[0]);
    for (int k = 1; k < NumStages; k++) begin
      pipe_d[k] = pipe_q[k-1];
      if (3'(k - 1) < pipe_q[k-1].len) begin
        pipe_d[k].crc = crc_byte(pipe_q[k-1].crc, pipe_q[k-1].bytes[k-1]);
      end
      vld_d[k] = adv[k-1] || (vld_q[k] && !adv[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pipe_q[0] <= pipe_d[0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (adv[k-1]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  bfb_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (adv[NumStages-1]),
    .item_i       (pipe_q[NumStages-1]),
    .free_o       (ser_free),
    .valid_o      (result_valid_o),
    .frame_byte_o (frame_byte_o),
    .last_o       (last_of_run_o),
    .is_chk_o     (is_check_result_o),
    .ok_o         (reply_ok_o),
    .rdata_o      (read_data_o)
  );

  a_chk_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_check_result_o |-> last_of_run_o)
    else $error("check result not marked last");

  a_run_gapless : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_run_o |=> result_valid_o && !is_check_result_o)
    else $error("frame run broken");

  a_chk_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_check_result_o |-> frame_byte_o == 8'h00)
    else $error("check result carries frame byte");

  a_frame_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !is_check_result_o |-> !reply_ok_o && read_data_o == 8'h00)
    else $error("frame byte carries check fields");

endmodule

`default_nettype wire

// File: tb/sv/tb_bridge_frame_builder_checker.sv
// Self-checking testbench for the bridge frame builder and reply checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_bridge_frame_builder_checker;
  import bfb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomRequests = 480;
  localparam int unsigned SettleCycles = 20;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       chk;
    logic       ok;
    logic [7:0] rdata;
  } frame_result_t;

  class frame_scoreboard;
    frame_result_t expected_results[$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function logic [15:0] crc16_next(input logic [15:0] acc_in, input logic [7:0] b);
      logic [15:0] acc;
      acc = acc_in ^ {8'h00, b};
      repeat (8) acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 16'h0000);
      return acc;
    endfunction

    function void note_request(input logic [2:0] op, input logic [5:0] dev,
                               input logic [15:0] regw, input logic [7:0] wv,
                               input logic [55:0] reply);
      logic [7:0]    frame [7];
      logic [7:0]    rx [7];
      int unsigned   n;
      int unsigned   s;
      logic [15:0]   acc;
      logic [15:0]   got_reg;
      logic [15:0]   got_crc;
      logic          ok;
      frame_result_t r;
      n = 0;
      acc = CRC_INIT;
      if (op == OP_CHK_SINGLE || op == OP_CHK_STACK) begin
        for (int i = 0; i < 7; i++) rx[i] = reply[8*i +: 8];
        s = (rx[0] == 8'h00) ? 1 : 0;
        got_reg = {rx[s+1], rx[s+2]};
        got_crc = {rx[s+5], rx[s+4]};
        for (int i = 0; i < 4 + s; i++) acc = crc16_next(acc, rx[i]);
        ok = (acc == got_crc) && (got_reg == regw);
        if (op == OP_CHK_SINGLE) ok = ok && (rx[s] == {2'b00, dev});
        r = '{frame_byte: 8'h00, last: 1'b1, chk: 1'b1, ok: ok, rdata: rx[s+3]};
        expected_results.push_back(r);
        return;
      end
      case (op)
        OP_SINGLE_WR, OP_SINGLE_RD: begin
          frame[0] = (op == OP_SINGLE_WR) ? CMD_SINGLE_WR : CMD_SINGLE_RD;
          frame[1] = {2'b00, dev};
          frame[2] = regw[15:8];
          frame[3] = regw[7:0];
          frame[4] = (op == OP_SINGLE_WR) ? wv : 8'h00;
          n = 5;
        end
        OP_STACK_WR, OP_BCAST_WR, OP_STACK_RD: begin
          frame[0] = (op == OP_STACK_WR) ? CMD_STACK_WR :
                     (op == OP_BCAST_WR) ? CMD_BCAST_WR : CMD_STACK_RD;
          frame[1] = regw[15:8];
          frame[2] = regw[7:0];
          frame[3] = (op == OP_STACK_RD) ? STACK_RD_DATA : wv;
          n = 4;
        end
        default: return;
      endcase
      for (int i = 0; i < n; i++) acc = crc16_next(acc, frame[i]);
      frame[n] = acc[7:0];
      frame[n+1] = acc[15:8];
      n = n + 2;
      for (int i = 0; i < n; i++) begin
        r = '{frame_byte: frame[i], last: (i == n - 1), chk: 1'b0, ok: 1'b0, rdata: 8'h00};
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h last=%b chk=%b ok=%b data=%h",
                   got.frame_byte, got.last, got.chk, got.ok, got.rdata);
        return;
      end
      want = expected_results.pop_front();
      if (got.frame_byte !== want.frame_byte || got.last !== want.last ||
          got.chk !== want.chk || got.ok !== want.ok || got.rdata !== want.rdata) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: byte %h/%h last %b/%b chk %b/%b ok %b/%b data %h/%h (exp/act)",
                   want.frame_byte, got.frame_byte, want.last, got.last, want.chk, got.chk,
                   want.ok, got.ok, want.rdata, got.rdata);
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  logic [5:0]  device_address_i;
  logic [15:0] register_address_i;
  logic [7:0]  write_value_i;
  logic [55:0] reply_bytes_i;
  logic        result_valid_o;
  logic [7:0]  frame_byte_o;
  logic        last_of_run_o;
  logic        is_check_result_o;
  logic        reply_ok_o;
  logic [7:0]  read_data_o;

  frame_scoreboard sb;
  int unsigned     cycle_count;
  int unsigned     burst_left;

  bridge_frame_builder_checker dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .device_address_i  (device_address_i),
    .register_address_i(register_address_i),
    .write_value_i     (write_value_i),
    .reply_bytes_i     (reply_bytes_i),
    .result_valid_o    (result_valid_o),
    .frame_byte_o      (frame_byte_o),
    .last_of_run_o     (last_of_run_o),
    .is_check_result_o (is_check_result_o),
    .reply_ok_o        (reply_ok_o),
    .read_data_o       (read_data_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result('{frame_byte: frame_byte_o, last: last_of_run_o,
                        chk: is_check_result_o, ok: reply_ok_o, rdata: read_data_o});
  end

  function automatic logic [55:0] rand_bits56();
    return 56'({$urandom(), $urandom()});
  endfunction

  function automatic logic [55:0] make_reply(input bit lead_zero, input logic [7:0] dev,
                                             input logic [15:0] regw, input logic [7:0] data,
                                             input logic [7:0] pad);
    logic [7:0]  b [7];
    logic [15:0] acc;
    logic [55:0] packed_reply;
    int unsigned s;
    s = lead_zero ? 1 : 0;
    b[0] = 8'h00;
    b[s] = dev;
    b[s+1] = regw[15:8];
    b[s+2] = regw[7:0];
    b[s+3] = data;
    acc = CRC_INIT;
    for (int i = 0; i < 4 + s; i++) acc = frame_scoreboard::crc16_next(acc, b[i]);
    b[s+4] = acc[7:0];
    b[s+5] = acc[15:8];
    if (!lead_zero) b[6] = pad;
    for (int i = 0; i < 7; i++) packed_reply[8*i +: 8] = b[i];
    return packed_reply;
  endfunction

  task automatic send(input logic [2:0] op, input logic [5:0] dev, input logic [15:0] regw,
                      input logic [7:0] wv, input logic [55:0] reply);
    @(negedge clk_i);
    start <= 1'b1;
    opcode_i <= op;
    device_address_i <= dev;
    register_address_i <= regw;
    write_value_i <= wv;
    reply_bytes_i <= reply;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, dev, regw, wv, reply);
  endtask

  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
      opcode_i <= 3'($urandom());
      reply_bytes_i <= rand_bits56();
    end
  endtask

  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [2:0]  op;
    logic [5:0]  dev;
    logic [15:0] regw;
    logic [7:0]  wv;
    logic [7:0]  rdev;
    logic [15:0] rreg;
    logic [55:0] reply;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    dev = 6'($urandom());
    regw = 16'($urandom());
    wv = 8'($urandom());
    reply = rand_bits56();
    if (pick < 45) begin
      op = 3'($urandom_range(OP_SINGLE_WR, OP_STACK_RD));
    end else if (pick < 85) begin
      op = ($urandom_range(0, 1) != 0) ? OP_CHK_SINGLE : OP_CHK_STACK;
      rdev = (op == OP_CHK_SINGLE) ? {2'b00, dev} : 8'($urandom());
      rreg = regw;
      reply = make_reply($urandom_range(0, 2) == 0, rdev, rreg, 8'($urandom()),
                         8'($urandom()));
      case ($urandom_range(0, 5))
        0: reply = reply ^ (56'd1 << $urandom_range(0, 55));
        1: regw = regw ^ (16'd1 << $urandom_range(0, 15));
        2: dev = dev ^ (6'd1 << $urandom_range(0, 5));
        default: ;
      endcase
    end else if (pick < 95) begin
      op = ($urandom_range(0, 1) != 0) ? OP_CHK_SINGLE : OP_CHK_STACK;
      if ($urandom_range(0, 3) == 0) reply[7:0] = 8'h00;
    end else begin
      op = OP_RESERVED;
    end
    send(op, dev, regw, wv, reply);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = '0;
    device_address_i = '0;
    register_address_i = '0;
    write_value_i = '0;
    reply_bytes_i = '0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send(OP_SINGLE_WR, 6'd0, 16'h0000, 8'h00, '0);
    send(OP_SINGLE_WR, 6'd63, 16'hFFFF, 8'hFF, '0);
    send(OP_STACK_WR, 6'd17, 16'h0000, 8'hFF, '0);
    send(OP_STACK_WR, 6'd63, 16'hFFFF, 8'h00, '0);
    send(OP_BCAST_WR, 6'd0, 16'h1234, 8'hA5, '0);
    send(OP_BCAST_WR, 6'd63, 16'hFFFF, 8'hFF, '0);
    send(OP_SINGLE_RD, 6'd63, 16'hFFFF, 8'h5A, '0);
    send(OP_SINGLE_RD, 6'd0, 16'h0000, 8'h00, '0);
    send(OP_STACK_RD, 6'd9, 16'h0000, 8'hFF, '0);
    send(OP_STACK_RD, 6'd63, 16'hFFFF, 8'h33, '0);
    send(OP_CHK_SINGLE, 6'd5, 16'h0102, 8'h00, make_reply(1'b0, 8'd5, 16'h0102, 8'hC3, 8'h77));
    send(OP_CHK_SINGLE, 6'd63, 16'hFFFF, 8'h00,
         make_reply(1'b1, 8'd63, 16'hFFFF, 8'hFF, 8'h00));
    send(OP_CHK_SINGLE, 6'd5, 16'h0102, 8'h00,
         make_reply(1'b0, 8'd5, 16'h0102, 8'hC3, 8'h00) ^ 56'h0100_0000_0000_00);
    send(OP_CHK_SINGLE, 6'd5, 16'h0103, 8'h00, make_reply(1'b0, 8'd5, 16'h0102, 8'hC3, 8'h00));
    send(OP_CHK_SINGLE, 6'd6, 16'h0102, 8'h00, make_reply(1'b0, 8'd5, 16'h0102, 8'hC3, 8'h00));
    send(OP_CHK_STACK, 6'd0, 16'hABCD, 8'h00, make_reply(1'b0, 8'hEE, 16'hABCD, 8'h00, 8'hFF));
    send(OP_CHK_STACK, 6'd0, 16'h0000, 8'h00, make_reply(1'b1, 8'h00, 16'h0000, 8'h00, 8'h00));
    send(OP_CHK_STACK, 6'd0, 16'h0000, 8'h00, 56'h0);
    send(OP_CHK_SINGLE, 6'd63, 16'hFFFF, 8'hFF, {56{1'b1}});
    send(OP_RESERVED, 6'd63, 16'hFFFF, 8'hFF, {56{1'b1}});
    drain();

    for (int unsigned i = 0; i < RandomRequests; i++) begin
      if (i == RandomRequests / 2) drain();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 60);
        end else begin
          idle($urandom_range(1, 8));
          burst_left = $urandom_range(1, 12);
        end
      end
      burst_left--;
      send_random();
    end

    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: bridge_frame_builder_checker.f
rtl/core/bfb_pkg.sv
rtl/core/bfb_serializer.sv
rtl/core/bridge_frame_builder_checker.sv
tb/sv/tb_bridge_frame_builder_checker.sv
